>>> hdl/ppu_pkg.sv
// ----------------------------------------------------------------------------
// ppu_pkg
// Shared types and constants of the particle physics update unit: payload
// records of both streaming channels, configuration register set and the
// register map of the APB port.
// ----------------------------------------------------------------------------
package ppu_pkg;

    // apb address width: eight 32-bit registers at byte addresses 4*i
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;
    localparam int IDX_W  = 3;

    // register indexes
    localparam logic [IDX_W-1:0] REG_TIME_STEP   = 3'd0;
    localparam logic [IDX_W-1:0] REG_GRAVITY_X   = 3'd1;
    localparam logic [IDX_W-1:0] REG_GRAVITY_Y   = 3'd2;
    localparam logic [IDX_W-1:0] REG_GRAVITY_Z   = 3'd3;
    localparam logic [IDX_W-1:0] REG_DRAG_COEFF  = 3'd4;
    localparam logic [IDX_W-1:0] REG_COLOR_BIRTH = 3'd5;
    localparam logic [IDX_W-1:0] REG_COLOR_DEATH = 3'd6;
    localparam logic [IDX_W-1:0] REG_SCALE_PAIR  = 3'd7;

    // input particle record
    typedef struct packed {
        logic               is_alive;
        logic signed [31:0] life_left;
        logic        [31:0] life_inverse;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] vel_z;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
    } t_ppu_in;

    // advanced particle record
    typedef struct packed {
        logic               alive_out;
        logic signed [31:0] life_out;
        logic signed [31:0] vel_x_out;
        logic signed [31:0] vel_y_out;
        logic signed [31:0] vel_z_out;
        logic signed [31:0] pos_x_out;
        logic signed [31:0] pos_y_out;
        logic signed [31:0] pos_z_out;
        logic        [31:0] rgba_out;
        logic signed [15:0] scale_out;
    } t_ppu_out;

    // configuration register set
    typedef struct packed {
        logic        [15:0] time_step;
        logic signed [31:0] gravity_x;
        logic signed [31:0] gravity_y;
        logic signed [31:0] gravity_z;
        logic        [15:0] drag_coeff;
        logic        [31:0] color_birth;
        logic        [31:0] color_death;
        logic        [31:0] scale_pair;
    } t_ppu_cfg;

endpackage

>>> hdl/particle_physics_update_unit.sv
// ----------------------------------------------------------------------------
// particle_physics_update_unit
// Euler step of one particle record per transaction: lifetime, gravity and
// drag on velocity, position integration, age-driven color and scale blend.
//
//   channel   dir  handshake                        payload
//   in        in   i_in_valid / o_in_ready          i_in_data  (t_ppu_in)
//   out       out  o_out_valid / i_out_ready        o_out_data (t_ppu_out)
//   config    in   psel penable pwrite / pready     paddr pwdata prdata
//
// One transaction per cycle sustained while i_out_ready stays high; each
// passes from acceptance to o_out_valid through the six register stages
// of the multiplier chain (gravity, drag, rescale, position products).
// Reset clears the configuration registers to zero and empties the pipe.
// A full stage holds while the next one holds; bubbles ahead of a stall
// are filled, so the input keeps taking transactions while results wait.
// ----------------------------------------------------------------------------
module particle_physics_update_unit #(
    parameter int FRAC_BITS = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  ppu_pkg::t_ppu_in            i_in_data,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output ppu_pkg::t_ppu_out           o_out_data,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ppu_pkg::ADDR_W-1:0]  paddr,
    input  logic [ppu_pkg::DATA_W-1:0]  pwdata,
    output logic [ppu_pkg::DATA_W-1:0]  prdata,
    output logic                        pready
);

    ppu_pkg::t_ppu_cfg w_cfg;

    // configuration registers
    ppu_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // update datapath
    ppu_pipe #(
        .FRAC_BITS (FRAC_BITS)
    ) u_pipe (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (w_cfg),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_data  (i_in_data),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (o_out_data)
    );

endmodule

>>> hdl/ppu_regs.sv
// ----------------------------------------------------------------------------
// ppu_regs
// APB register file of the particle update unit. Zero wait states; writes
// land at the access phase, reads return the addressed register.
// ----------------------------------------------------------------------------
module ppu_regs (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ppu_pkg::ADDR_W-1:0]  paddr,
    input  logic [ppu_pkg::DATA_W-1:0]  pwdata,
    output logic [ppu_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    output ppu_pkg::t_ppu_cfg           o_cfg
);

    ppu_pkg::t_ppu_cfg           r_cfg;
    ppu_pkg::t_ppu_cfg           n_cfg;
    logic [ppu_pkg::IDX_W-1:0]   w_idx;
    logic                        w_wr;

    assign pready = 1'b1;
    assign w_idx  = paddr[ppu_pkg::ADDR_W-1:2];
    assign w_wr   = psel && penable && pwrite;
    assign o_cfg  = r_cfg;

    // write decode
    always_comb begin
        n_cfg = r_cfg;
        if (w_wr) begin
            unique case (w_idx)
                ppu_pkg::REG_TIME_STEP:   n_cfg.time_step   = pwdata[15:0];
                ppu_pkg::REG_GRAVITY_X:   n_cfg.gravity_x   = pwdata;
                ppu_pkg::REG_GRAVITY_Y:   n_cfg.gravity_y   = pwdata;
                ppu_pkg::REG_GRAVITY_Z:   n_cfg.gravity_z   = pwdata;
                ppu_pkg::REG_DRAG_COEFF:  n_cfg.drag_coeff  = pwdata[15:0];
                ppu_pkg::REG_COLOR_BIRTH: n_cfg.color_birth = pwdata;
                ppu_pkg::REG_COLOR_DEATH: n_cfg.color_death = pwdata;
                ppu_pkg::REG_SCALE_PAIR:  n_cfg.scale_pair  = pwdata;
                default:                  n_cfg = r_cfg;
            endcase
        end
    end

    // register storage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // read mux
    always_comb begin
        unique case (w_idx)
            ppu_pkg::REG_TIME_STEP:   prdata = {16'b0, r_cfg.time_step};
            ppu_pkg::REG_GRAVITY_X:   prdata = r_cfg.gravity_x;
            ppu_pkg::REG_GRAVITY_Y:   prdata = r_cfg.gravity_y;
            ppu_pkg::REG_GRAVITY_Z:   prdata = r_cfg.gravity_z;
            ppu_pkg::REG_DRAG_COEFF:  prdata = {16'b0, r_cfg.drag_coeff};
            ppu_pkg::REG_COLOR_BIRTH: prdata = r_cfg.color_birth;
            ppu_pkg::REG_COLOR_DEATH: prdata = r_cfg.color_death;
            ppu_pkg::REG_SCALE_PAIR:  prdata = r_cfg.scale_pair;
            default:                  prdata = '0;
        endcase
    end

endmodule

>>> hdl/ppu_pipe.sv
// ----------------------------------------------------------------------------
// ppu_pipe
// Six-stage datapath of the particle update: lifetime and gravity, velocity
// sum and age product, drag multiply and age, velocity saturation and blend
// products, position product and blend, position add and output register.
// ----------------------------------------------------------------------------
module ppu_pipe #(
    parameter int FRAC_BITS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ppu_pkg::t_ppu_cfg   i_cfg,
    input  logic                i_valid,
    output logic                o_ready,
    input  ppu_pkg::t_ppu_in    i_data,
    output logic                o_valid,
    input  logic                i_ready,
    output ppu_pkg::t_ppu_out   o_data
);

    localparam int NSTG = 6;
    localparam int TSH  = 2 * FRAC_BITS - 16;
    localparam logic [63:0] ONE_Q = 64'(1) << (2 * FRAC_BITS);

    // record fields that ride along the pipe
    typedef struct packed {
        logic             live;
        logic             alive;
        logic [31:0]      life;
        logic [2:0][31:0] vel;
        logic [2:0][31:0] pos;
    } t_carry;

    function automatic logic [31:0] f_sat35(input logic [34:0] v);
        if (v[34:31] == 4'b0000 || v[34:31] == 4'b1111) begin
            return v[31:0];
        end else if (v[34]) begin
            return 32'h8000_0000;
        end else begin
            return 32'h7FFF_FFFF;
        end
    endfunction

    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] w_en;
    t_carry          r_cy [NSTG-1];
    t_carry          n_cy;

    // stage A
    logic [47:0]        w_dt_wide;
    logic [31:0]        w_dtf;
    logic [32:0]        w_life_diff;
    logic [31:0]        w_life_new;
    logic               w_upd;
    logic               w_live;
    logic signed [47:0] w_gprod [3];
    logic [31:0]        w_grav [3];
    logic [31:0]        w_dprod;
    logic [31:0]        r_a_gdt [3];
    logic [31:0]        r_a_inv;
    logic [31:0]        r_a_dprod;

    // stage B
    logic [32:0]        r_b_sum [3];
    logic [24:0]        r_b_damp;
    logic [63:0]        r_b_prod;

    // stage C
    logic signed [58:0] w_m [3];
    logic [63:0]        w_tdiff;
    logic [16:0]        w_t;
    logic signed [58:0] r_c_m [3];
    logic [16:0]        r_c_t;

    // stage D
    logic [8:0]         w_cd [4];
    logic signed [26:0] w_cprod [4];
    logic [16:0]        w_sd;
    logic signed [34:0] w_sprod;
    logic [31:0]        r_d_vn [3];
    logic signed [26:0] r_d_cprod [4];
    logic [34:0]        r_d_sprod;

    // stage E
    logic signed [47:0] w_pm [3];
    logic [27:0]        w_csum [4];
    logic [11:0]        w_cval [4];
    logic [31:0]        w_rgba;
    logic [35:0]        w_ssum;
    logic [31:0]        r_e_vn [3];
    logic signed [47:0] r_e_pm [3];
    logic [31:0]        r_e_rgba;
    logic [15:0]        r_e_scale;

    // stage F
    logic [34:0]        w_psum [3];
    logic [31:0]        w_pnew [3];
    ppu_pkg::t_ppu_out  n_out;
    ppu_pkg::t_ppu_out  r_out;

    // per-stage load enables, a stage loads when empty or when it drains
    always_comb begin
        w_en[NSTG-1] = !r_vld[NSTG-1] || i_ready;
        for (int k = NSTG - 2; k >= 0; k--) begin
            w_en[k] = !r_vld[k] || w_en[k+1];
        end
    end

    assign o_ready = w_en[0];
    assign o_valid = r_vld[NSTG-1];
    assign o_data  = r_out;

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (w_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // stage A: lifetime step, death check, gravity and drag products
    always_comb begin
        w_upd       = i_data.is_alive && (i_cfg.time_step != '0);
        w_dt_wide   = 48'(i_cfg.time_step) << FRAC_BITS;
        w_dtf       = w_dt_wide[47:16];
        w_life_diff = {i_data.life_left[31], i_data.life_left} - {1'b0, w_dtf};
        if (w_life_diff[32] == w_life_diff[31]) begin
            w_life_new = w_life_diff[31:0];
        end else if (w_life_diff[32]) begin
            w_life_new = 32'h8000_0000;
        end else begin
            w_life_new = 32'h7FFF_FFFF;
        end
        w_live = w_upd && !w_life_new[31] && (w_life_new != '0);

        w_grav[0] = i_cfg.gravity_x;
        w_grav[1] = i_cfg.gravity_y;
        w_grav[2] = i_cfg.gravity_z;
        for (int i = 0; i < 3; i++) begin
            w_gprod[i] = $signed(w_grav[i]) * $signed({1'b0, i_cfg.time_step});
        end
        w_dprod = 32'(i_cfg.drag_coeff) * 32'(i_cfg.time_step);

        n_cy.live   = w_live;
        n_cy.alive  = w_upd ? w_live : i_data.is_alive;
        n_cy.life   = w_upd ? w_life_new : i_data.life_left;
        n_cy.vel[0] = i_data.vel_x;
        n_cy.vel[1] = i_data.vel_y;
        n_cy.vel[2] = i_data.vel_z;
        n_cy.pos[0] = i_data.pos_x;
        n_cy.pos[1] = i_data.pos_y;
        n_cy.pos[2] = i_data.pos_z;
    end

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_cy[0]   <= n_cy;
            r_a_inv   <= i_data.life_inverse;
            r_a_dprod <= w_dprod;
            for (int i = 0; i < 3; i++) begin
                r_a_gdt[i] <= w_gprod[i][47:16];
            end
        end
    end

    // stage B: velocity plus gravity step, damp clamp, age product
    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            r_cy[1] <= r_cy[0];
            for (int i = 0; i < 3; i++) begin
                r_b_sum[i] <= {r_cy[0].vel[i][31], r_cy[0].vel[i]}
                            + {r_a_gdt[i][31], r_a_gdt[i]};
            end
            if (r_a_dprod[31:24] != '0) begin
                r_b_damp <= '0;
            end else begin
                r_b_damp <= 25'h100_0000 - {1'b0, r_a_dprod[23:0]};
            end
            r_b_prod <= 64'(r_cy[0].life) * 64'(r_a_inv);
        end
    end

    // stage C: drag multiply, age t from the lifetime product
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_m[i] = $signed(r_b_sum[i]) * $signed({1'b0, r_b_damp});
        end
        w_tdiff = ONE_Q - r_b_prod;
        w_t     = (r_b_prod < ONE_Q) ? 17'(w_tdiff >> TSH) : '0;
    end

    always_ff @(posedge i_clk) begin
        if (w_en[2]) begin
            r_cy[2] <= r_cy[1];
            r_c_m   <= w_m;
            r_c_t   <= w_t;
        end
    end

    // stage D: velocity rescale and saturation, blend products
    always_comb begin
        for (int c = 0; c < 4; c++) begin
            w_cd[c] = {1'b0, i_cfg.color_death[24-8*c +: 8]}
                    - {1'b0, i_cfg.color_birth[24-8*c +: 8]};
            w_cprod[c] = $signed(w_cd[c]) * $signed({1'b0, r_c_t});
        end
        w_sd    = {i_cfg.scale_pair[15], i_cfg.scale_pair[15:0]}
                - {i_cfg.scale_pair[31], i_cfg.scale_pair[31:16]};
        w_sprod = $signed(w_sd) * $signed({1'b0, r_c_t});
    end

    always_ff @(posedge i_clk) begin
        if (w_en[3]) begin
            r_cy[3]   <= r_cy[2];
            r_d_cprod <= w_cprod;
            r_d_sprod <= w_sprod;
            for (int i = 0; i < 3; i++) begin
                r_d_vn[i] <= f_sat35(r_c_m[i][58:24]);
            end
        end
    end

    // stage E: velocity times dt, color and scale blend
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_pm[i] = $signed(r_d_vn[i]) * $signed({1'b0, i_cfg.time_step});
        end
        for (int c = 0; c < 4; c++) begin
            w_csum[c] = {4'b0, i_cfg.color_birth[24-8*c +: 8], 16'b0}
                      + {r_d_cprod[c][26], r_d_cprod[c]};
            w_cval[c] = w_csum[c][27:16];
            if (w_cval[c][11]) begin
                w_rgba[24-8*c +: 8] = 8'd0;
            end else if (w_cval[c][10:8] != '0) begin
                w_rgba[24-8*c +: 8] = 8'd255;
            end else begin
                w_rgba[24-8*c +: 8] = w_cval[c][7:0];
            end
        end
        w_ssum = {{4{i_cfg.scale_pair[31]}}, i_cfg.scale_pair[31:16], 16'b0}
               + {r_d_sprod[34], r_d_sprod};
    end

    always_ff @(posedge i_clk) begin
        if (w_en[4]) begin
            r_cy[4]   <= r_cy[3];
            r_e_vn    <= r_d_vn;
            r_e_pm    <= w_pm;
            r_e_rgba  <= w_rgba;
            r_e_scale <= w_ssum[31:16];
        end
    end

    // stage F: position add, pass-through select for untouched records
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_psum[i] = {{3{r_cy[4].pos[i][31]}}, r_cy[4].pos[i]}
                      + {{3{r_e_pm[i][47]}}, r_e_pm[i][47:16]};
            w_pnew[i] = f_sat35(w_psum[i]);
        end
        n_out.alive_out = r_cy[4].alive;
        n_out.life_out  = r_cy[4].life;
        if (r_cy[4].live) begin
            n_out.vel_x_out = r_e_vn[0];
            n_out.vel_y_out = r_e_vn[1];
            n_out.vel_z_out = r_e_vn[2];
            n_out.pos_x_out = w_pnew[0];
            n_out.pos_y_out = w_pnew[1];
            n_out.pos_z_out = w_pnew[2];
            n_out.rgba_out  = r_e_rgba;
            n_out.scale_out = r_e_scale;
        end else begin
            n_out.vel_x_out = r_cy[4].vel[0];
            n_out.vel_y_out = r_cy[4].vel[1];
            n_out.vel_z_out = r_cy[4].vel[2];
            n_out.pos_x_out = r_cy[4].pos[0];
            n_out.pos_y_out = r_cy[4].pos[1];
            n_out.pos_z_out = r_cy[4].pos[2];
            n_out.rgba_out  = '0;
            n_out.scale_out = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[NSTG-1]) begin
            r_out <= n_out;
        end
    end

    // input side only backs up when every stage holds a waiting transaction
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> (&r_vld) && !i_ready)
        else $error("input stalled while the pipe has room");

    // an accepted transaction lands in the first stage
    a_accept_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> r_vld[0])
        else $error("accepted transaction not captured");

    // records that leave dead carry no color or scale
    a_dead_blank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_data.alive_out |-> o_data.rgba_out == '0 && o_data.scale_out == '0)
        else $error("dead particle with blend output");

    // the stage before the output register keeps a transaction that cannot move
    a_stage_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[NSTG-2] && !w_en[NSTG-2] |=> r_vld[NSTG-2])
        else $error("stalled stage dropped its transaction");

endmodule

>>> verif/particle_physics_update_unit_test.sv
// ----------------------------------------------------------------------------
// particle_physics_update_unit_test
// Self-checking bench for the particle Euler step. A behavioral copy of the
// fixed-point update predicts each advanced record at input acceptance; a
// monitor compares every output transaction field by field, in order. APB
// writes and readback cover the register set, then directed corner records
// and a randomized stream over several configurations, with random idling
// on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module particle_physics_update_unit_test;

    typedef longint unsigned t_u64;
    typedef logic [ppu_pkg::IDX_W-1:0] t_reg_idx;

    localparam int     FRAC          = 16;
    localparam int     HALF_PERIOD   = 5;
    localparam int     RESET_CYCLES  = 8;
    localparam int     TAIL_CYCLES   = 20;
    localparam int     CYCLE_LIMIT   = 600000;
    localparam int     PHASE_COUNT   = 8;
    localparam int     PHASE_RECORDS = 250;
    localparam int     MAX_PRINTS    = 100;
    localparam longint Q_MAX         = 64'sd2147483647;
    localparam longint Q_MIN         = -64'sd2147483648;
    localparam logic [31:0] ONE_Q    = 32'h0001_0000;

    // clock, reset and block ports
    logic                        i_clk     = 1'b0;
    logic                        i_rst_n   = 1'b0;
    logic                        in_valid  = 1'b0;
    logic                        in_ready;
    ppu_pkg::t_ppu_in            in_data   = '0;
    logic                        out_valid;
    logic                        out_ready = 1'b0;
    ppu_pkg::t_ppu_out           out_data;
    logic                        psel      = 1'b0;
    logic                        penable   = 1'b0;
    logic                        pwrite    = 1'b0;
    logic [ppu_pkg::ADDR_W-1:0]  paddr     = '0;
    logic [ppu_pkg::DATA_W-1:0]  pwdata    = '0;
    logic [ppu_pkg::DATA_W-1:0]  prdata;
    logic                        pready;

    // bench state
    ppu_pkg::t_ppu_cfg  cfg_model = '0;
    ppu_pkg::t_ppu_out  pending_records[$];
    ppu_pkg::t_ppu_out  oldest_record;
    int        particles_sent  = 0;
    int        records_checked = 0;
    int        mismatch_count  = 0;
    int        phases_run      = 0;
    int        cycle_count     = 0;
    int        stall_left      = 0;
    bit        tx_idle_en      = 1'b0;
    bit        rx_idle_en      = 1'b0;

    particle_physics_update_unit #(
        .FRAC_BITS (FRAC)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // fixed-point update of one particle
    // ------------------------------------------------------------------
    function automatic longint clamp_q32(longint v);
        if (v > Q_MAX) return Q_MAX;
        if (v < Q_MIN) return Q_MIN;
        return v;
    endfunction

    // gravity kick then drag damping, floor shifts
    function automatic longint damped_velocity(longint v, logic [31:0] g, longint ts,
                                               longint damp);
        longint g_dt;
        g_dt = (longint'($signed(g)) * ts) >>> 16;
        return clamp_q32(((v + g_dt) * damp) >>> 24);
    endfunction

    function automatic ppu_pkg::t_ppu_out advance_particle(ppu_pkg::t_ppu_in p,
                                                           ppu_pkg::t_ppu_cfg c);
        ppu_pkg::t_ppu_out r;
        longint      ts, life, dt_q, damp, age, c0, c1, chan, s0, s1, sc;
        longint      vel[3];
        longint      pos[3];
        logic [31:0] grav[3];
        t_u64        age_prod, one_q;
        r.alive_out = p.is_alive;
        r.life_out  = p.life_left;
        r.vel_x_out = p.vel_x;
        r.vel_y_out = p.vel_y;
        r.vel_z_out = p.vel_z;
        r.pos_x_out = p.pos_x;
        r.pos_y_out = p.pos_y;
        r.pos_z_out = p.pos_z;
        r.rgba_out  = '0;
        r.scale_out = '0;
        ts = longint'(c.time_step);
        // dead particles and a zero frame pass through
        if (!p.is_alive || ts == 0) return r;

        dt_q = (ts << FRAC) >>> 16;
        life = clamp_q32(longint'($signed(p.life_left)) - dt_q);
        r.life_out = life[31:0];
        if (life <= 0) begin
            r.alive_out = 1'b0;
            return r;
        end

        damp = 64'sd1 << 24;
        if (c.drag_coeff != 0) begin
            damp -= longint'(c.drag_coeff) * ts;
            if (damp < 0) damp = 0;
        end
        vel[0] = longint'($signed(p.vel_x));
        vel[1] = longint'($signed(p.vel_y));
        vel[2] = longint'($signed(p.vel_z));
        pos[0] = longint'($signed(p.pos_x));
        pos[1] = longint'($signed(p.pos_y));
        pos[2] = longint'($signed(p.pos_z));
        grav[0] = c.gravity_x;
        grav[1] = c.gravity_y;
        grav[2] = c.gravity_z;
        for (int i = 0; i < 3; i++) begin
            vel[i] = damped_velocity(vel[i], grav[i], ts, damp);
            pos[i] = clamp_q32(pos[i] + ((vel[i] * ts) >>> 16));
        end
        r.vel_x_out = vel[0][31:0];
        r.vel_y_out = vel[1][31:0];
        r.vel_z_out = vel[2][31:0];
        r.pos_x_out = pos[0][31:0];
        r.pos_y_out = pos[1][31:0];
        r.pos_z_out = pos[2][31:0];

        // normalized age drives the color and scale blend
        one_q    = t_u64'(1) << (2 * FRAC);
        age_prod = t_u64'(life) * t_u64'(p.life_inverse);
        age = 0;
        if (age_prod < one_q) age = longint'((one_q - age_prod) >> (2 * FRAC - 16));
        if (age > 65536) age = 65536;
        for (int ch = 0; ch < 4; ch++) begin
            c0   = longint'(c.color_birth[24 - 8 * ch +: 8]);
            c1   = longint'(c.color_death[24 - 8 * ch +: 8]);
            chan = (c0 * 65536 + (c1 - c0) * age) >>> 16;
            if (chan < 0) chan = 0;
            if (chan > 255) chan = 255;
            r.rgba_out[24 - 8 * ch +: 8] = chan[7:0];
        end
        s0 = longint'($signed(c.scale_pair[31:16]));
        s1 = longint'($signed(c.scale_pair[15:0]));
        sc = (s0 * 65536 + (s1 - s0) * age) >>> 16;
        r.scale_out = sc[15:0];
        return r;
    endfunction

    // ------------------------------------------------------------------
    // mismatch reporting and record comparison
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTS)
            $display("mismatch %s at record %0d: got %08h want %08h (t=%0t)",
                     what, records_checked, got, want, $realtime);
    endtask

    task automatic check_record(input ppu_pkg::t_ppu_out got,
                                input ppu_pkg::t_ppu_out want);
        if (got.alive_out !== want.alive_out)
            report_mismatch("alive_out", 32'(got.alive_out), 32'(want.alive_out));
        if (got.life_out !== want.life_out)
            report_mismatch("life_out", got.life_out, want.life_out);
        if (got.vel_x_out !== want.vel_x_out)
            report_mismatch("vel_x_out", got.vel_x_out, want.vel_x_out);
        if (got.vel_y_out !== want.vel_y_out)
            report_mismatch("vel_y_out", got.vel_y_out, want.vel_y_out);
        if (got.vel_z_out !== want.vel_z_out)
            report_mismatch("vel_z_out", got.vel_z_out, want.vel_z_out);
        if (got.pos_x_out !== want.pos_x_out)
            report_mismatch("pos_x_out", got.pos_x_out, want.pos_x_out);
        if (got.pos_y_out !== want.pos_y_out)
            report_mismatch("pos_y_out", got.pos_y_out, want.pos_y_out);
        if (got.pos_z_out !== want.pos_z_out)
            report_mismatch("pos_z_out", got.pos_z_out, want.pos_z_out);
        if (got.rgba_out !== want.rgba_out)
            report_mismatch("rgba_out", got.rgba_out, want.rgba_out);
        if (got.scale_out !== want.scale_out)
            report_mismatch("scale_out", 32'(got.scale_out), 32'(want.scale_out));
    endtask

    // output monitor: every accepted transaction against the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && out_valid && out_ready) begin
            if (pending_records.size() == 0) begin
                report_mismatch("unexpected result", out_data.life_out, 32'h0);
            end else begin
                oldest_record = pending_records.pop_front();
                check_record(out_data, oldest_record);
            end
            records_checked++;
        end
    end

    // ------------------------------------------------------------------
    // idling on both channels
    // ------------------------------------------------------------------
    function automatic int idle_length();
        if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
        return $urandom_range(1, 3);
    endfunction

    // receiver back-pressure
    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            out_ready  <= 1'b0;
        end else if (rx_idle_en && $urandom_range(0, 3) == 0) begin
            stall_left <= idle_length() - 1;
            out_ready  <= 1'b0;
        end else begin
            out_ready <= 1'b1;
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d records outstanding",
                     cycle_count, pending_records.size());
            $display("** particle_physics_update_unit: FAILED **");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // input transactions
    // ------------------------------------------------------------------
    task automatic send_particle(input ppu_pkg::t_ppu_in p);
        int gap;
        in_data  <= p;
        in_valid <= 1'b1;
        do @(posedge i_clk); while (!in_ready);
        pending_records.push_back(advance_particle(p, cfg_model));
        particles_sent++;
        gap = (tx_idle_en && $urandom_range(0, 2) == 0) ? idle_length() : 0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // stop sending and let every predicted record come back
    task automatic wait_drained();
        in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_records.size() != 0);
    endtask

    // ------------------------------------------------------------------
    // configuration port
    // ------------------------------------------------------------------
    function automatic logic [31:0] reg_mask(t_reg_idx idx);
        if (idx == ppu_pkg::REG_TIME_STEP || idx == ppu_pkg::REG_DRAG_COEFF)
            return 32'h0000_FFFF;
        return 32'hFFFF_FFFF;
    endfunction

    task automatic write_reg(input t_reg_idx idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        case (idx)
            ppu_pkg::REG_TIME_STEP:   cfg_model.time_step   = value[15:0];
            ppu_pkg::REG_GRAVITY_X:   cfg_model.gravity_x   = value;
            ppu_pkg::REG_GRAVITY_Y:   cfg_model.gravity_y   = value;
            ppu_pkg::REG_GRAVITY_Z:   cfg_model.gravity_z   = value;
            ppu_pkg::REG_DRAG_COEFF:  cfg_model.drag_coeff  = value[15:0];
            ppu_pkg::REG_COLOR_BIRTH: cfg_model.color_birth = value;
            ppu_pkg::REG_COLOR_DEATH: cfg_model.color_death = value;
            ppu_pkg::REG_SCALE_PAIR:  cfg_model.scale_pair  = value;
            default: ;
        endcase
    endtask

    // read sampled mid-cycle in the access phase
    task automatic check_reg(input t_reg_idx idx, input logic [31:0] want);
        logic [31:0] got;
        logic        done;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge i_clk);
        penable <= 1'b1;
        do begin
            @(negedge i_clk);
            got  = prdata;
            done = pready;
            @(posedge i_clk);
        end while (!done);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        if ((got & reg_mask(idx)) !== (want & reg_mask(idx)))
            report_mismatch("register readback", got, want);
    endtask

    task automatic program_config(input logic [15:0] ts, input logic [31:0] gx,
                                  input logic [31:0] gy, input logic [31:0] gz,
                                  input logic [15:0] drag, input logic [31:0] c_birth,
                                  input logic [31:0] c_death, input logic [31:0] scales);
        write_reg(ppu_pkg::REG_TIME_STEP, 32'(ts));
        write_reg(ppu_pkg::REG_GRAVITY_X, gx);
        write_reg(ppu_pkg::REG_GRAVITY_Y, gy);
        write_reg(ppu_pkg::REG_GRAVITY_Z, gz);
        write_reg(ppu_pkg::REG_DRAG_COEFF, 32'(drag));
        write_reg(ppu_pkg::REG_COLOR_BIRTH, c_birth);
        write_reg(ppu_pkg::REG_COLOR_DEATH, c_death);
        write_reg(ppu_pkg::REG_SCALE_PAIR, scales);
    endtask

    function automatic logic [31:0] random_gravity();
        if ($urandom_range(0, 3) == 0) return $urandom;
        return int'($urandom_range(0, 1 << 24)) - (1 << 23);
    endfunction

    task automatic random_config();
        logic [15:0] ts;
        logic [15:0] drag;
        ts   = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(1, 16'h0100))
                                           : 16'($urandom_range(1, 16'hFFFF));
        drag = 16'h0000;
        if ($urandom_range(0, 1) == 0)
            drag = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(1, 16'hFFFF))
                                               : 16'($urandom_range(1, 16'h0400));
        program_config(ts, random_gravity(), random_gravity(), random_gravity(), drag,
                       $urandom, $urandom, $urandom);
    endtask

    // ------------------------------------------------------------------
    // particle records
    // ------------------------------------------------------------------
    function automatic ppu_pkg::t_ppu_in make_particle(logic alive, logic [31:0] life,
                                                       logic [31:0] inv, logic [31:0] vel,
                                                       logic [31:0] pos);
        ppu_pkg::t_ppu_in p;
        p.is_alive     = alive;
        p.life_left    = life;
        p.life_inverse = inv;
        p.vel_x        = vel;
        p.vel_y        = ~vel;
        p.vel_z        = {vel[15:0], vel[31:16]};
        p.pos_x        = pos;
        p.pos_y        = ~pos;
        p.pos_z        = {pos[15:0], pos[31:16]};
        return p;
    endfunction

    function automatic logic [31:0] random_motion();
        if ($urandom_range(0, 4) == 0) return $urandom;
        return int'($urandom_range(0, 1 << 23)) - (1 << 22);
    endfunction

    // mostly plausible particles with consistent lifetime and inverse, some noise
    function automatic ppu_pkg::t_ppu_in random_particle();
        ppu_pkg::t_ppu_in p;
        logic [31:0]      inv;
        if ($urandom_range(0, 3) == 0) begin
            p.is_alive     = 1'($urandom_range(0, 1));
            p.life_left    = $urandom;
            p.life_inverse = $urandom;
            p.vel_x        = $urandom;
            p.vel_y        = $urandom;
            p.vel_z        = $urandom;
            p.pos_x        = $urandom;
            p.pos_y        = $urandom;
            p.pos_z        = $urandom;
        end else begin
            inv            = $urandom_range(16, 1 << 20);
            p.is_alive     = ($urandom_range(0, 15) != 0);
            p.life_inverse = inv;
            if ($urandom_range(0, 9) == 0)
                p.life_left = $urandom_range(1, 2 * int'(cfg_model.time_step) + 1);
            else
                p.life_left = $urandom_range(1, 32'hFFFF_FFFF / inv);
            p.vel_x = random_motion();
            p.vel_y = random_motion();
            p.vel_z = random_motion();
            p.pos_x = random_motion();
            p.pos_y = random_motion();
            p.pos_z = random_motion();
        end
        return p;
    endfunction

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // registers clear on reset and a zero frame passes records through
    task automatic test_reset_state();
        for (int i = 0; i < 8; i++) check_reg(t_reg_idx'(i), 32'h0);
        send_particle(make_particle(1'b1, ONE_Q, ONE_Q, 32'h0001_2345, 32'hFFF0_0000));
        send_particle(make_particle(1'b0, 32'h8000_0000, 32'hFFFF_FFFF,
                                    32'h7FFF_FFFF, 32'h8000_0000));
        send_particle(random_particle());
        wait_drained();
    endtask

    // write and read back every register with extreme and mixed patterns
    task automatic test_register_access();
        logic [31:0] pattern;
        for (int k = 0; k < 4; k++) begin
            for (int i = 0; i < 8; i++) begin
                case (k)
                    0:       pattern = 32'hFFFF_FFFF;
                    1:       pattern = 32'hA5A5_5A5A;
                    2:       pattern = $urandom;
                    default: pattern = 32'h0000_0000;
                endcase
                write_reg(t_reg_idx'(i), pattern);
                check_reg(t_reg_idx'(i), pattern);
            end
        end
    endtask

    // corner records: death, saturation, age limits, damping limits, zero frame
    task automatic test_directed_cases();
        program_config(16'h1000, 32'h7FFF_FFFF, 32'hFFF6_3333, 32'h8000_0000, 16'h0100,
                       32'hFF80_4000, 32'h00FF_80FF, {16'h0200, 16'h8000});
        send_particle(make_particle(1'b0, ONE_Q, ONE_Q, 32'h0001_0000, 32'h0002_0000));
        send_particle(make_particle(1'b1, ONE_Q, ONE_Q, 32'h0, 32'h0));
        send_particle(make_particle(1'b1, 32'h0000_1000, ONE_Q, 32'h0001_0000, 32'h0));
        send_particle(make_particle(1'b1, 32'h0000_0FFF, ONE_Q, 32'h0001_0000, 32'h0));
        send_particle(make_particle(1'b1, 32'h8000_0000, ONE_Q, 32'h0, 32'h0));
        send_particle(make_particle(1'b1, 32'h7FFF_FFFF, 32'h0, 32'h0003_0000, 32'h0));
        send_particle(make_particle(1'b1, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0, 32'h0));
        send_particle(make_particle(1'b1, ONE_Q, 32'h0000_8000, 32'h7FFF_FFFF,
                                    32'h7FFF_FFFF));
        send_particle(make_particle(1'b1, ONE_Q, 32'h0000_8000, 32'h8000_0000,
                                    32'h8000_0000));
        send_particle(make_particle(1'b0, 32'hFFFF_0000, 32'h0, 32'h8000_0000,
                                    32'h7FFF_FFFF));
        wait_drained();

        // damping driven to zero by the largest drag and frame
        program_config(16'hFFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 16'hFFFF,
                       32'h00FF_00FF, 32'hFF00_FF00, {16'h7FFF, 16'h8000});
        send_particle(make_particle(1'b1, 32'h0010_0000, 32'h0000_1000, 32'h0123_4567,
                                    32'h0765_4321));
        send_particle(make_particle(1'b1, 32'h0001_0000, 32'h0000_FFFF, 32'h8000_0000,
                                    32'h7FFF_0000));
        send_particle(make_particle(1'b1, 32'h0000_FFFF, ONE_Q, 32'h0001_0000, 32'h0));
        wait_drained();

        // zero frame: even live particles pass through
        write_reg(ppu_pkg::REG_TIME_STEP, 32'h0);
        send_particle(make_particle(1'b1, 32'h0000_0001, ONE_Q, 32'h7FFF_FFFF, 32'h1));
        send_particle(make_particle(1'b1, 32'h8000_0000, 32'hFFFF_FFFF, 32'h8000_0000,
                                    32'hFFFF_FFFF));
        wait_drained();

        // no damping, largest frame, back to back with the receiver stalling
        program_config(16'hFFFF, 32'h0009_CCCC, 32'hFFF6_3333, 32'h0000_0000, 16'h0000,
                       32'hFFFF_FFFF, 32'h0000_0000, {16'h8000, 16'h7FFF});
        rx_idle_en = 1'b1;
        send_particle(make_particle(1'b1, 32'h0040_0000, 32'h0000_0400, 32'h7FFF_0000,
                                    32'h7FFF_F000));
        send_particle(make_particle(1'b1, 32'h0002_0000, 32'h0000_8000, 32'h8000_1000,
                                    32'h8000_0100));
        send_particle(make_particle(1'b1, 32'h0001_0000, 32'h0001_0000, 32'h0, 32'h0));
        wait_drained();
    endtask

    // randomized stream over several configurations, extremes among them
    task automatic test_random_stream();
        for (int ph = 0; ph < PHASE_COUNT; ph++) begin
            case (ph)
                1: program_config(16'hFFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                  16'hFFFF, 32'hFFFF_FFFF, 32'h0000_0000,
                                  {16'h7FFF, 16'h7FFF});
                2: program_config(16'h0001, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                  16'h0000, 32'h0000_0000, 32'hFFFF_FFFF,
                                  {16'h8000, 16'h8000});
                3: write_reg(ppu_pkg::REG_TIME_STEP, 32'h0);
                default: random_config();
            endcase
            tx_idle_en = (ph % 3 != 0);
            rx_idle_en = (ph % 4 != 0);
            for (int n = 0; n < PHASE_RECORDS; n++) begin
                // sender holds off once until the pipe has emptied
                if (ph == 4 && n == PHASE_RECORDS / 2) wait_drained();
                send_particle(random_particle());
            end
            wait_drained();
            phases_run++;
        end
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_state();
        test_register_access();
        test_directed_cases();
        test_random_stream();

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("covered %0d particle records (%0d results checked) over %0d random phases",
                 particles_sent, records_checked, phases_run);
        $display("corner records, register readback and two-sided idling, %0d mismatches",
                 mismatch_count);
        if (mismatch_count == 0) begin
            $display("** particle_physics_update_unit: PASSED **");
        end else begin
            $display("** particle_physics_update_unit: FAILED **");
        end
        $finish;
    end

endmodule
